>>> hdl/knn_pkg.sv
// Shared types and constants for the k-nearest-neighbor pixel fill block.
package knn_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DIST,
    ST_SQRT,
    ST_INS,
    ST_SUM,
    ST_MAXB,
    ST_POW,
    ST_CRD,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam logic [0:0] REG_NEIGHBOR = 1'b0;
  localparam logic [0:0] REG_EXPONENT = 1'b1;

  localparam int unsigned BASE_LIMIT_BITS = 13;
  localparam int unsigned MAX_EXPONENT    = 4;

  // Distance: sqrt of a value with up to 2*12+1+16 bits, so up to 21 result bits.
  localparam int unsigned DIST_BITS  = 26;
  localparam int unsigned RAD_BITS   = 2 * DIST_BITS;
  localparam int unsigned TOT_BITS   = DIST_BITS + 4;
  localparam int unsigned WGT_BITS   = 4 * BASE_LIMIT_BITS;
  localparam int unsigned WSUM_BITS  = WGT_BITS + 4;
  localparam int unsigned ACC_BITS   = WSUM_BITS + 8;

endpackage

>>> hdl/knn_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module knn_sqrt (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [knn_pkg::RAD_BITS-1:0]         rad_i,
  output logic                                 busy_o,
  output logic [knn_pkg::DIST_BITS-1:0]        root_o
);
  localparam int unsigned RB = knn_pkg::RAD_BITS;
  localparam int unsigned DB = knn_pkg::DIST_BITS;

  logic [RB-1:0]         rem_q, rem_d;
  logic [DB-1:0]         root_q, root_d;
  logic [RB-1:0]         rad_q, rad_d;
  logic [$clog2(DB+1)-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [RB-1:0]         trial;
  logic [RB-1:0]         rem_sh;

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    rad_d  = rad_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q[RB-3:0], rad_q[RB-1 -: 2]};
    trial  = RB'({root_q, 2'b01});
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      rad_d  = rad_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RB-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[DB-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[DB-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(DB+1))'(DB - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;
endmodule

>>> hdl/knn_div.sv
// Restoring divider, one quotient bit per cycle, with half-up rounding.
module knn_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [knn_pkg::ACC_BITS-1:0]       num_i,
  input  logic [knn_pkg::WSUM_BITS-1:0]      den_i,
  output logic                               busy_o,
  output logic [7:0]                         quo_o
);
  localparam int unsigned AB = knn_pkg::ACC_BITS;
  localparam int unsigned WB = knn_pkg::WSUM_BITS;

  logic [AB-1:0]           num_q;
  logic [AB-1:0]           quo_q;
  logic [WB:0]             rem_q;
  logic [WB-1:0]           den_q;
  logic [$clog2(AB+1)-1:0] cnt_q;
  logic                    busy_q;
  logic [WB:0]             rem_sh;
  logic [WB+1:0]           twice;
  logic [AB:0]             rq;

  assign rem_sh = {rem_q[WB-1:0], num_q[AB-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ($clog2(AB+1))'(AB - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[AB-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[AB-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[AB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    twice = {rem_q, 1'b0};
    rq    = {1'b0, quo_q} + ((twice >= {2'b00, den_q}) ? (AB+1)'(1) : '0);
    quo_o = (rq > (AB+1)'(255)) ? 8'hFF : rq[7:0];
  end

  assign busy_o = busy_q;
endmodule

>>> hdl/knn_weighted_pixel_fill.sv
// Top level of the distance-weighted k-nearest-neighbor pixel fill block.
//
//  channel   dir   handshake              payload
//  s_axis    in    s_axis_tvalid/tready   command, pos_x, pos_y, in_red/green/blue
//  m_axis    out   m_axis_tvalid/tready   out_red/green/blue, is_sample_hit, neighbors_used
//  apb       in    psel/penable/pready    neighbor_count (0x0), weight_exponent (0x4)
//
// Clear and load finish in the cycle that accepts them. A query reads each stored
// sample once, stopping at a sample on the query position, and runs it through
// one shared bit-serial square root unit. It then sums the distances, settles
// the base shift and forms the weights, and takes the weighted mean of each
// channel in the shared divider. Reset empties the store (sample count zero) and
// loads the register defaults. Input is not ready while an item is in work; a
// result waits in the output register until taken.
module knn_weighted_pixel_fill #(
  parameter int unsigned MAX_SAMPLES   = 1024,
  parameter int unsigned COORD_BITS    = 12,
  parameter int unsigned MAX_NEIGHBORS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] command, [13:2] pos_x, [25:14] pos_y, [33:26] red, [41:34] green, [49:42] blue
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue, [24] is_sample_hit, [28:25] neighbors_used
  output logic [31:0] m_axis_tdata_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned AW  = $clog2(MAX_SAMPLES);
  localparam int unsigned NW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned KW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned SW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned DB  = knn_pkg::DIST_BITS;
  localparam int unsigned TB  = knn_pkg::TOT_BITS;
  localparam int unsigned WB  = knn_pkg::WGT_BITS;
  localparam int unsigned WSB = knn_pkg::WSUM_BITS;
  localparam int unsigned ACB = knn_pkg::ACC_BITS;
  localparam int unsigned LB  = knn_pkg::BASE_LIMIT_BITS;

  // ---- configuration registers ----
  logic [3:0] nbr_q;
  logic [2:0] exp_q;
  logic       cfg_we;
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbr_q <= 4'd3;
      exp_q <= 3'd3;
    end else if (cfg_we && paddr_i[1:0] == 2'b00) begin
      if (paddr_i[2] == knn_pkg::REG_NEIGHBOR) begin
        nbr_q <= pwdata_i[3:0];
      end else begin
        exp_q <= pwdata_i[2:0];
      end
    end
  end
  always_comb begin
    prdata_o = '0;
    if (paddr_i[1:0] == 2'b00) begin
      if (paddr_i[2] == knn_pkg::REG_NEIGHBOR) prdata_o = {28'd0, nbr_q};
      else prdata_o = {29'd0, exp_q};
    end
  end

  // ---- sample memories ----
  logic [2*CB-1:0] xy_mem  [MAX_SAMPLES];
  logic [23:0]     col_mem [MAX_SAMPLES];
  logic [2*CB-1:0] xy_rd_q;
  logic [23:0]     col_rd_q;
  logic            mem_we;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [2*CB-1:0] wr_xy;
  logic [23:0]     wr_col;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      xy_mem[wr_addr]  <= wr_xy;
      col_mem[wr_addr] <= wr_col;
    end
    xy_rd_q  <= xy_mem[rd_addr];
    col_rd_q <= col_mem[rd_addr];
  end

  // ---- state ----
  knn_pkg::state_e st_q, st_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic [NW-1:0]   idx_q, idx_d;
  logic [CB-1:0]   qx_q, qx_d, qy_q, qy_d;
  logic [1:0]      cmd_in;
  logic [KW-1:0]   k_q, k_d, n_q, n_d;
  logic [2:0]      e_q, e_d;
  logic [DB-1:0]   seld_q [MAX_NEIGHBORS];
  logic [AW-1:0]   seli_q [MAX_NEIGHBORS];
  logic [DB-1:0]   seld_d [MAX_NEIGHBORS];
  logic [AW-1:0]   seli_d [MAX_NEIGHBORS];
  logic [WB-1:0]   w_q [MAX_NEIGHBORS];
  logic [WB-1:0]   w_d [MAX_NEIGHBORS];
  logic [TB-1:0]   tot_q, tot_d, maxb_q, maxb_d;
  logic [SW-1:0]   j_q, j_d;
  logic [2:0]      t_q, t_d;
  logic [1:0]      ch_q, ch_d;
  logic [ACB-1:0]  acc_q, acc_d;
  logic [WSB-1:0]  wsum_q, wsum_d;
  logic [WB-1:0]   b_q, b_d, p_q, p_d;
  logic [23:0]     ocol_q, ocol_d;
  logic            ohit_q, ohit_d;
  logic [3:0]      onu_q, onu_d;
  logic            ov_q, ov_d;
  logic [CB-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic [5:0]      sh_q, sh_d;

  // shared units
  logic                         sq_start, sq_busy;
  logic [knn_pkg::RAD_BITS-1:0] sq_rad;
  logic [DB-1:0]                sq_root;
  logic                         dv_start, dv_busy;
  logic [7:0]                   dv_quo;
  logic [2*CB:0]                rad_sum;

  assign rad_sum = (2*CB+1)'(dx_q) * (2*CB+1)'(dx_q) + (2*CB+1)'(dy_q) * (2*CB+1)'(dy_q);
  assign sq_rad  = knn_pkg::RAD_BITS'({rad_sum, 16'd0});

  knn_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad), .busy_o(sq_busy), .root_o(sq_root)
  );
  knn_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(acc_q), .den_i(wsum_q),
    .busy_o(dv_busy), .quo_o(dv_quo)
  );

  logic [CB-1:0] sx, sy;
  logic [KW-1:0] pos, last;
  logic [TB-1:0] base;
  logic [7:0]    chan;
  logic [WB+7:0] prod8;
  logic [WB+LB-1:0] prodw;

  assign cmd_in = s_axis_tdata_i[1:0];
  assign sx     = xy_rd_q[CB-1:0];
  assign sy     = xy_rd_q[2*CB-1:CB];
  assign s_axis_tready_o = (st_q == knn_pkg::ST_IDLE) && !ov_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; idx_d = idx_q; qx_d = qx_q; qy_d = qy_q;
    k_d = k_q; n_d = n_q; e_d = e_q; tot_d = tot_q; maxb_d = maxb_q;
    j_d = j_q; t_d = t_q; ch_d = ch_q; acc_d = acc_q; wsum_d = wsum_q;
    b_d = b_q; p_d = p_q; ocol_d = ocol_q; ohit_d = ohit_q; onu_d = onu_q;
    ov_d = ov_q; dx_d = dx_q; dy_d = dy_q; sh_d = sh_q;
    seld_d = seld_q; seli_d = seli_q; w_d = w_q;
    mem_we = 1'b0; wr_addr = cnt_q[AW-1:0];
    wr_xy  = {s_axis_tdata_i[14+CB-1:14], s_axis_tdata_i[2+CB-1:2]};
    wr_col = s_axis_tdata_i[49:26];
    rd_addr = idx_q[AW-1:0];
    sq_start = 1'b0; dv_start = 1'b0;
    pos = n_q; last = '0;
    base = '0; chan = '0; prod8 = '0; prodw = '0;
    if (ov_q && m_axis_tready_i) ov_d = 1'b0;
    unique case (st_q)
      knn_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          qx_d = s_axis_tdata_i[2+CB-1:2];
          qy_d = s_axis_tdata_i[14+CB-1:14];
          unique case (knn_pkg::cmd_e'(cmd_in))
            knn_pkg::CMD_CLEAR: cnt_d = '0;
            knn_pkg::CMD_LOAD: begin
              if (cnt_q < NW'(MAX_SAMPLES)) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
              end
            end
            knn_pkg::CMD_QUERY: begin
              k_d = (nbr_q == 4'd0) ? KW'(1) :
                    ({1'b0, nbr_q} > 5'(MAX_NEIGHBORS)) ? KW'(MAX_NEIGHBORS) : KW'(nbr_q);
              e_d = (exp_q > 3'(knn_pkg::MAX_EXPONENT)) ? 3'(knn_pkg::MAX_EXPONENT) : exp_q;
              n_d = '0; idx_d = '0;
              ocol_d = '0; ohit_d = 1'b0; onu_d = '0;
              st_d = knn_pkg::ST_RD;
            end
            default: ;
          endcase
        end
      end
      knn_pkg::ST_RD: begin
        if (idx_q >= cnt_q) st_d = knn_pkg::ST_SUM;
        else st_d = knn_pkg::ST_DIST;
      end
      knn_pkg::ST_DIST: begin
        if (sx == qx_q && sy == qy_q) begin
          ocol_d = col_rd_q; ohit_d = 1'b1; onu_d = '0;
          ov_d = 1'b1; st_d = knn_pkg::ST_OUT;
        end else begin
          dx_d = (sx > qx_q) ? sx - qx_q : qx_q - sx;
          dy_d = (sy > qy_q) ? sy - qy_q : qy_q - sy;
          st_d = knn_pkg::ST_SQRT;
          t_d  = 3'd0;
        end
      end
      knn_pkg::ST_SQRT: begin
        if (t_q == 3'd0) begin
          sq_start = 1'b1; t_d = 3'd1;
        end else if (t_q == 3'd1) begin
          t_d = 3'd2;
        end else if (!sq_busy) begin
          st_d = knn_pkg::ST_INS;
        end
      end
      knn_pkg::ST_INS: begin
        for (int j = MAX_NEIGHBORS - 1; j >= 0; j--) begin
          if (KW'(j) < n_q && sq_root < seld_q[j]) pos = KW'(j);
        end
        if (pos < k_q) begin
          last = (n_q < k_q) ? n_q : k_q - 1'b1;
          for (int j = MAX_NEIGHBORS - 1; j > 0; j--) begin
            if (KW'(j) <= last && KW'(j) > pos) begin
              seld_d[j] = seld_q[j-1]; seli_d[j] = seli_q[j-1];
            end
          end
          for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            if (KW'(j) == pos) begin
              seld_d[j] = sq_root; seli_d[j] = idx_q[AW-1:0];
            end
          end
          if (n_q < k_q) n_d = n_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        st_d = knn_pkg::ST_RD;
        j_d = '0; tot_d = '0; maxb_d = '0;
      end
      knn_pkg::ST_SUM: begin
        if (n_q == '0) begin
          ov_d = 1'b1; st_d = knn_pkg::ST_OUT;
        end else begin
          tot_d = tot_q + TB'(seld_q[j_q]);
          if (KW'(j_q) == n_q - 1'b1) begin
            j_d = '0; st_d = knn_pkg::ST_MAXB;
          end else j_d = j_q + 1'b1;
        end
        onu_d = 4'(n_q);
      end
      knn_pkg::ST_MAXB: begin
        base = tot_q - TB'(seld_q[j_q]);
        if (base > maxb_d) maxb_d = base;
        if (KW'(j_q) == n_q - 1'b1) begin
          j_d = '0; sh_d = '0; st_d = knn_pkg::ST_POW; t_d = 3'd7; wsum_d = '0;
        end else j_d = j_q + 1'b1;
      end
      knn_pkg::ST_POW: begin
        // first settle the shift, then one multiply per cycle per weight
        if ((maxb_q >> sh_q) >= TB'(1 << LB)) begin
          sh_d = sh_q + 1'b1;
        end else if (t_q == 3'd7) begin
          b_d = WB'((tot_q - TB'(seld_q[j_q])) >> sh_q);
          p_d = WB'(1); t_d = 3'd0;
        end else if (t_q < e_q) begin
          // the reduced base always fits in LB bits
          prodw = (WB+LB)'(p_q) * (WB+LB)'(b_q[LB-1:0]);
          p_d = prodw[WB-1:0]; t_d = t_q + 1'b1;
        end else begin
          w_d[j_q] = p_q;
          wsum_d = wsum_q + WSB'(p_q);
          t_d = 3'd7;
          if (KW'(j_q) == n_q - 1'b1) begin
            ch_d = '0; j_d = '0; acc_d = '0; st_d = knn_pkg::ST_CRD;
          end else j_d = j_q + 1'b1;
        end
      end
      knn_pkg::ST_CRD: begin
        rd_addr = seli_q[j_q];
        if (wsum_q == '0) begin
          rd_addr = seli_q[0];
          t_d = 3'd0;
        end
        st_d = knn_pkg::ST_ACC;
      end
      knn_pkg::ST_ACC: begin
        if (wsum_q == '0) begin
          ocol_d = col_rd_q; ov_d = 1'b1; st_d = knn_pkg::ST_OUT;
        end else begin
          chan  = col_rd_q[8*ch_q +: 8];
          prod8 = (WB+8)'(chan) * (WB+8)'(w_q[j_q]);
          acc_d = acc_q + ACB'(prod8);
          if (KW'(j_q) == n_q - 1'b1) begin
            dv_start = 1'b0; t_d = 3'd0; st_d = knn_pkg::ST_DIV;
          end else begin
            j_d = j_q + 1'b1; st_d = knn_pkg::ST_CRD;
          end
        end
      end
      knn_pkg::ST_DIV: begin
        if (t_q == 3'd0) begin
          dv_start = 1'b1; t_d = 3'd1;
        end else if (t_q == 3'd1) begin
          t_d = 3'd2;
        end else if (!dv_busy) begin
          ocol_d[8*ch_q +: 8] = dv_quo;
          if (ch_q == 2'd2) begin
            ov_d = 1'b1; st_d = knn_pkg::ST_OUT;
          end else begin
            ch_d = ch_q + 1'b1; j_d = '0; acc_d = '0; st_d = knn_pkg::ST_CRD;
          end
        end
      end
      knn_pkg::ST_OUT: st_d = knn_pkg::ST_IDLE;
      default: st_d = knn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= knn_pkg::ST_IDLE;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; qx_q <= qx_d; qy_q <= qy_d; k_q <= k_d; n_q <= n_d; e_q <= e_d;
    seld_q <= seld_d; seli_q <= seli_d; w_q <= w_d; tot_q <= tot_d; maxb_q <= maxb_d;
    j_q <= j_d; t_q <= t_d; ch_q <= ch_d; acc_q <= acc_d; wsum_q <= wsum_d;
    b_q <= b_d; p_q <= p_d; ocol_q <= ocol_d; ohit_q <= ohit_d; onu_q <= onu_d;
    dx_q <= dx_d; dy_q <= dy_d; sh_q <= sh_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {3'd0, onu_q, ohit_q, ocol_q};

  // A result is only offered once a query has finished.
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(st_q) != knn_pkg::ST_IDLE) else $error("unexpected result");
  // A hit never reports neighbors.
  a_hit_no_nbr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ohit_q) |-> onu_q == 4'd0) else $error("hit with neighbors");
  // Sample count never exceeds capacity.
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(MAX_SAMPLES)) else $error("store overflow");
endmodule
